// File: hdl/te2f_pkg.sv
`default_nettype none
package te2f_pkg;

    typedef enum logic [3:0] {
        TYPE_BOOL = 4'd0,
        TYPE_I8   = 4'd1,
        TYPE_U8   = 4'd2,
        TYPE_I16  = 4'd3,
        TYPE_U16  = 4'd4,
        TYPE_I32  = 4'd5,
        TYPE_U32  = 4'd6,
        TYPE_I64  = 4'd7,
        TYPE_U64  = 4'd8,
        TYPE_F16  = 4'd9,
        TYPE_F32  = 4'd10,
        TYPE_F64  = 4'd11
    } elem_type_t;

    localparam logic [0:0] REG_ELEMENT_TYPE = 1'b0;
    localparam logic [0:0] REG_BIG_ENDIAN   = 1'b1;

    localparam logic [31:0] F32_ONE = 32'h3F80_0000;
    localparam logic [31:0] F32_INF = 32'h7F80_0000;

    // Conversion path chosen in the front stage.
    typedef enum logic [2:0] {
        PATH_ZERO = 3'd0,
        PATH_INT  = 3'd1,
        PATH_DIRECT = 3'd2,
        PATH_F64  = 3'd3
    } path_t;

    // Word handed from the front stage to the normalize stage.
    typedef struct packed {
        path_t       path;
        logic        neg;
        logic [63:0] mag;      // integer magnitude, or f64 significand with hidden bit
        logic [31:0] direct;   // finished result for bool, f16, f32, specials
        logic [10:0] dexp;     // f64 biased exponent
        logic        last;
    } front_t;

    // Word handed from the normalize stage to the round stage.
    typedef struct packed {
        path_t       path;
        logic        neg;
        logic [63:0] norm;     // magnitude shifted so the value sits at a known point
        logic [8:0]  exp_base; // exponent field before rounding carry
        logic        is_zero;
        logic [31:0] direct;
        logic        last;
    } norm_t;

endpackage
`default_nettype wire

// File: hdl/typed_element_to_float32_top.sv
`default_nettype none
// Converts one element of the configured numeric type per word into IEEE-754
// single bits, rounding to nearest even. Three register stages (decode and
// byte swap, normalize, round) give a rate of one word per cycle; a stall on
// the output holds every stage in place.
// Write element_type and big_endian only while no word is in flight.
module typed_element_to_float32_top
    import te2f_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [3:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // raw_bits
    input  wire logic        s_tlast,   // last_in
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // float_bits
    output logic             m_tlast    // last_out
);

    logic [3:0]  type_reg;
    logic        be_reg;
    front_t      front_next, front_reg;
    norm_t       norm_next, norm_reg;
    logic [31:0] res_next, res_reg;
    logic        last_reg;
    logic        v1_reg, v2_reg, v3_reg;
    logic        adv;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg <= TYPE_U8;
            be_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_ELEMENT_TYPE)
                type_reg <= cfg_wdata;
            else
                be_reg <= cfg_wdata[0];
        end
    end

    te2f_front u_front (
        .element_type(type_reg), .big_endian(be_reg), .raw_bits(s_tdata),
        .last_in(s_tlast), .front(front_next)
    );
    te2f_norm u_norm (.front(front_reg), .norm(norm_next));
    te2f_round u_round (.norm(norm_reg), .result(res_next));

    // The whole pipe moves when the output slot is free or being taken.
    assign adv = !v3_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            front_reg <= front_next;
            norm_reg <= norm_next;
            res_reg <= res_next;
            last_reg <= norm_reg.last;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata = res_reg;
    assign m_tlast = last_reg;

    // A stalled output word must hold.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output word changed under stall");
    // No input is taken while the output word is stalled.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");
    // A word accepted now shows as valid in stage one.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted word lost");

endmodule
`default_nettype wire

// File: hdl/te2f_front.sv
`default_nettype none
module te2f_front
    import te2f_pkg::*;
(
    input  wire logic [3:0]  element_type,
    input  wire logic        big_endian,
    input  wire logic [63:0] raw_bits,
    input  wire logic        last_in,
    output front_t           front
);

    logic [63:0] masked;
    logic [63:0] v;
    logic [63:0] sv;
    logic [9:0]  hman;
    logic [4:0]  hexp;
    logic [31:0] hres;
    logic [4:0]  hsh;
    logic [9:0]  hm2;

    // Mask to element width and swap bytes for big-endian files.
    always_comb
    begin
        masked = raw_bits;
        v = raw_bits;
        case (element_type) inside
            TYPE_BOOL, TYPE_I8, TYPE_U8:
            begin
                masked = {56'd0, raw_bits[7:0]};
                v = masked;
            end
            TYPE_I16, TYPE_U16, TYPE_F16:
            begin
                masked = {48'd0, raw_bits[15:0]};
                v = big_endian ? {48'd0, raw_bits[7:0], raw_bits[15:8]} : masked;
            end
            TYPE_I32, TYPE_U32, TYPE_F32:
            begin
                masked = {32'd0, raw_bits[31:0]};
                v = big_endian ? {32'd0, raw_bits[7:0], raw_bits[15:8],
                                  raw_bits[23:16], raw_bits[31:24]} : masked;
            end
            default:
            begin
                v = big_endian ? {raw_bits[7:0], raw_bits[15:8], raw_bits[23:16],
                                  raw_bits[31:24], raw_bits[39:32], raw_bits[47:40],
                                  raw_bits[55:48], raw_bits[63:56]} : raw_bits;
            end
        endcase
    end

    // Half widening: renormalize subnormals with a short priority search.
    always_comb
    begin
        hexp = v[14:10];
        hman = v[9:0];
        hsh = 5'd0;
        hm2 = 10'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (hman[i])
            begin
                hsh = 5'(10 - i);
                hm2 = 10'(hman << (10 - i));
            end
        end
        if (hexp == 5'd0)
        begin
            if (hman == 10'd0)
                hres = {v[15], 31'd0};
            else
                hres = {v[15], 8'(8'd113 - {3'd0, hsh}), hm2, 13'd0};
        end
        else if (hexp == 5'h1F)
            hres = {v[15], 8'hFF, hman, 13'd0};
        else
            hres = {v[15], 8'({3'd0, hexp} + 8'd112), hman, 13'd0};
    end

    // Sign-extend signed integers.
    always_comb
    begin
        case (element_type) inside
            TYPE_I8:  sv = {{56{v[7]}}, v[7:0]};
            TYPE_I16: sv = {{48{v[15]}}, v[15:0]};
            TYPE_I32: sv = {{32{v[31]}}, v[31:0]};
            default:  sv = v;
        endcase
    end

    always_comb
    begin
        front = '0;
        front.last = last_in;
        front.dexp = v[62:52];
        case (element_type) inside
            TYPE_BOOL:
            begin
                front.path = PATH_DIRECT;
                front.direct = (v != 64'd0) ? F32_ONE : 32'd0;
            end
            TYPE_I8, TYPE_I16, TYPE_I32, TYPE_I64:
            begin
                front.path = PATH_INT;
                front.neg = sv[63];
                front.mag = sv[63] ? (~sv + 64'd1) : sv;
            end
            TYPE_U8, TYPE_U16, TYPE_U32, TYPE_U64:
            begin
                front.path = PATH_INT;
                front.mag = v;
            end
            TYPE_F16:
            begin
                front.path = PATH_DIRECT;
                front.direct = hres;
            end
            TYPE_F32:
            begin
                front.path = PATH_DIRECT;
                front.direct = v[31:0];
            end
            TYPE_F64:
            begin
                front.neg = v[63];
                front.mag = {11'd0, 1'b1, v[51:0]};
                if (v[62:52] == 11'h7FF)
                begin
                    front.path = PATH_DIRECT;
                    front.direct = (v[51:0] != 52'd0)
                        ? {v[63], 8'hFF, 1'b1, v[50:29]} : {v[63], F32_INF[30:0]};
                end
                else if (v[62:52] == 11'd0)
                begin
                    front.path = PATH_DIRECT;
                    front.direct = {v[63], 31'd0};
                end
                else
                    front.path = PATH_F64;
            end
            default:
                front.path = PATH_ZERO;
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/te2f_norm.sv
`default_nettype none
module te2f_norm
    import te2f_pkg::*;
(
    input  front_t front,
    output norm_t  norm
);

    logic [5:0]  lead;
    logic [11:0] sh;

    // Leading-one position for integers.
    always_comb
    begin
        lead = 6'd0;
        for (int i = 0; i < 64; i++)
            if (front.mag[i])
                lead = 6'(i);
    end

    // Integers: put the leading one at bit 63. The exponent field is 126+p,
    // plus the hidden bit added back in by rounding's sum.
    // Doubles: shift right so the single LSB lands at bit 29 of the word,
    // i.e. right shift by the extra subnormal distance.
    always_comb
    begin
        norm = '0;
        norm.path = front.path;
        norm.neg = front.neg;
        norm.direct = front.direct;
        norm.last = front.last;
        sh = 12'd0;
        if (front.path == PATH_INT)
        begin
            norm.is_zero = (front.mag == 64'd0);
            norm.norm = front.mag << (6'd63 - lead);
            norm.exp_base = 9'(9'd126 + {3'd0, lead});
        end
        else if (front.path == PATH_F64)
        begin
            if (front.dexp >= 11'd897)
            begin
                norm.norm = front.mag;
                // Exponents past the single range saturate; rounding then gives infinity.
                if (front.dexp >= 11'd1152)
                    norm.exp_base = 9'd255;
                else
                    norm.exp_base = 9'(front.dexp - 11'd897);
            end
            else
            begin
                sh = {1'b0, 11'(11'd897 - front.dexp)};
                norm.exp_base = 9'd0;
                if (sh > 12'd34)
                    norm.is_zero = 1'b1;
                else
                    norm.norm = front.mag >> sh[5:0];
                // sticky of shifted-out bits
                if (sh <= 12'd34 && ((front.mag & ((64'd1 << sh[5:0]) - 64'd1)) != 64'd0))
                    norm.norm[0] = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/te2f_round.sv
`default_nettype none
module te2f_round
    import te2f_pkg::*;
(
    input  norm_t       norm,
    output logic [31:0] result
);

    logic [23:0] keep;
    logic        rnd;
    logic [31:0] sum;

    // Round to nearest even and add to the exponent field; a mantissa carry
    // rolls into the exponent by itself.
    always_comb
    begin
        keep = 24'd0;
        rnd = 1'b0;
        sum = 32'd0;
        result = 32'd0;
        case (norm.path)
            PATH_INT:
            begin
                keep = norm.norm[63:40];
                rnd = norm.norm[39] && ((norm.norm[38:0] != 39'd0) || keep[0]);
                sum = {norm.exp_base, 23'd0} + {8'd0, keep} + {31'd0, rnd};
                result = norm.is_zero ? {norm.neg, 31'd0} : {norm.neg, sum[30:0]};
            end
            PATH_F64:
            begin
                keep = norm.norm[52:29];
                rnd = norm.norm[28] && ((norm.norm[27:0] != 28'd0) || keep[0]);
                sum = {norm.exp_base, 23'd0} + {8'd0, keep} + {31'd0, rnd};
                if (norm.is_zero)
                    result = {norm.neg, 31'd0};
                else if (sum >= F32_INF)
                    result = {norm.neg, F32_INF[30:0]};
                else
                    result = {norm.neg, sum[30:0]};
            end
            PATH_DIRECT:
                result = norm.direct;
            default:
                result = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// File: tb/sv/tb_typed_element_to_float32_top.sv
`default_nettype none
module tb_typed_element_to_float32_top;
    import te2f_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_WORDS   = 78;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [3:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // raw_bits
    logic        s_tlast;   // last_in
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // float_bits
    logic        m_tlast;   // last_out

    typedef struct {
        logic [31:0] float_bits;
        logic        last_out;
    } float_word_t;

    typedef struct {
        logic [3:0]  etype;
        logic        be;
        logic [63:0] raw;
        logic        last;
        logic        typed;     // 1 when want_bits below is given by hand
        logic [31:0] want_bits;
    } stim_row_t;

    float_word_t pending_floats[$];
    logic [3:0]  cur_type;
    logic        cur_be;
    int          error_count;
    int          words_sent;
    int          words_checked;
    int          cycle_count;
    bit          idle_off;
    bit          hold_done;
    int          stall_left;

    typed_element_to_float32_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Shift right with round to nearest, ties to even; sh in 1..63.
    function automatic logic [63:0] shift_rne(logic [63:0] m, int sh);
        logic [63:0] keep;
        logic [63:0] rem;
        logic [63:0] half;
        keep = m >> sh;
        rem  = m & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && keep[0]))
            keep = keep + 64'd1;
        return keep;
    endfunction

    // Integer magnitude plus sign to single bits.
    function automatic logic [31:0] int_to_single(logic [63:0] m, logic neg);
        int          msb;
        logic [63:0] keep;
        logic [63:0] sum;
        if (m == 64'd0)
            return {neg, 31'd0};
        msb = 63;
        while (!m[msb])
            msb--;
        if (msb <= 23)
            keep = m << (23 - msb);
        else
            keep = shift_rne(m, msb - 23);
        sum = (64'(126 + msb) << 23) + keep;
        return {neg, 31'd0} | sum[31:0];
    endfunction

    function automatic logic [31:0] half_to_single_bits(logic [15:0] h);
        logic [4:0]  ex;
        logic [10:0] man;
        int          sh;
        ex  = h[14:10];
        man = {1'b0, h[9:0]};
        if (ex == 5'd0)
        begin
            if (man == 11'd0)
                return {h[15], 31'd0};
            sh = 0;
            while (!man[10])
            begin
                man = man << 1;
                sh++;
            end
            return {h[15], 8'(113 - sh), man[9:0], 13'd0};
        end
        if (ex == 5'h1F)
            return {h[15], 8'hFF, h[9:0], 13'd0};
        return {h[15], 8'(ex + 112), h[9:0], 13'd0};
    endfunction

    function automatic logic [31:0] double_to_single_bits(logic [63:0] d);
        logic [10:0] ex;
        logic [51:0] frac;
        logic [63:0] sig;
        logic [63:0] bits;
        ex   = d[62:52];
        frac = d[51:0];
        sig  = {12'd1, frac};
        if (ex == 11'h7FF)
        begin
            if (frac != 52'd0)
                return {d[63], 8'hFF, frac[51:29]} | 32'h0040_0000;
            return {d[63], 31'd0} | F32_INF;
        end
        if (ex == 11'd0)
            return {d[63], 31'd0};
        if (ex >= 11'd897)
        begin
            bits = (64'(ex - 11'd897) << 23) + shift_rne(sig, 29);
            if (bits >= 64'(F32_INF))
                bits = 64'(F32_INF);
            return {d[63], bits[30:0]};
        end
        if (29 + 897 - int'(ex) > 63)
            return {d[63], 31'd0};
        bits = shift_rne(sig, 29 + 897 - int'(ex));
        return {d[63], bits[30:0]};
    endfunction

    function automatic int element_bytes(logic [3:0] t);
        case (t)
            TYPE_BOOL, TYPE_I8, TYPE_U8:    return 1;
            TYPE_I16, TYPE_U16, TYPE_F16:   return 2;
            TYPE_I32, TYPE_U32, TYPE_F32:   return 4;
            TYPE_I64, TYPE_U64, TYPE_F64:   return 8;
            default:                        return 0;
        endcase
    endfunction

    // Expected single bits for one element under the given settings.
    function automatic logic [31:0] convert_element(logic [3:0] t, logic be, logic [63:0] raw);
        int          nb;
        logic [63:0] v;
        logic [63:0] r;
        nb = element_bytes(t);
        v  = raw;
        if (nb > 0 && nb < 8)
            v = v & ((64'd1 << (8 * nb)) - 64'd1);
        if (be && nb > 1)
        begin
            r = 64'd0;
            for (int i = 0; i < nb; i++)
                r[8 * (nb - 1 - i) +: 8] = v[8 * i +: 8];
            v = r;
        end
        case (t)
            TYPE_BOOL: return (v != 64'd0) ? F32_ONE : 32'd0;
            TYPE_I8:   v = {{56{v[7]}}, v[7:0]};
            TYPE_I16:  v = {{48{v[15]}}, v[15:0]};
            TYPE_I32:  v = {{32{v[31]}}, v[31:0]};
            TYPE_U8, TYPE_U16, TYPE_U32, TYPE_U64: return int_to_single(v, 1'b0);
            TYPE_F16:  return half_to_single_bits(v[15:0]);
            TYPE_F32:  return v[31:0];
            TYPE_F64:  return double_to_single_bits(v);
            TYPE_I64:  ;
            default:   return 32'd0;
        endcase
        return int_to_single(v[63] ? (~v + 64'd1) : v, v[63]);
    endfunction

    // Random element biased toward the interesting corners of each type.
    function automatic logic [63:0] random_element(logic [3:0] t);
        logic [63:0] v;
        int          pick;
        v    = {$urandom, $urandom};
        pick = $urandom_range(9);
        if (t == TYPE_F64)
        begin
            case (pick)
                0:       v[62:52] = 11'd0;
                1:       v[62:52] = 11'h7FF;
                2, 3:    v[62:52] = 11'($urandom_range(960, 850));
                4:       v[62:52] = 11'($urandom_range(1160, 1145));
                5:       v[28:0]  = 29'h1000_0000;
                default: v[62:52] = 11'($urandom_range(1150, 870));
            endcase
        end
        else if (t == TYPE_F16 && pick < 3)
            v[14:10] = (pick == 0) ? 5'd0 : 5'h1F;
        else if (pick == 0)
            v = v & 64'hFF;
        else if (pick == 1)
            v = v & ~64'hFF_FFFF_FFFF;
        return v;
    endfunction

    // Idle lengths: mostly none or short, now and then long.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    task automatic write_settings(logic [3:0] t, logic be);
        while (pending_floats.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ELEMENT_TYPE;
        cfg_wdata <= t;
        @(posedge clk);
        cfg_index <= REG_BIG_ENDIAN;
        cfg_wdata <= {3'd0, be};
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_type = t;
        cur_be   = be;
    endtask

    // Offer one word and wait until it is taken; queue its expected result.
    task automatic send_word(logic [63:0] raw, logic last, logic typed, logic [31:0] want);
        float_word_t exp_word;
        int          gap;
        gap = idle_off ? 0 : idle_cycles();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        exp_word.float_bits = typed ? want : convert_element(cur_type, cur_be, raw);
        exp_word.last_out   = last;
        pending_floats.insert(pending_floats.size(), exp_word);
        words_sent++;
    endtask

    // Directed rows; the expected value is given only where it is obvious.
    stim_row_t directed_rows[] = '{
        '{TYPE_U8,   1'b0, 64'h0,                 1'b0, 1'b1, 32'h0000_0000},
        '{TYPE_U8,   1'b0, 64'hFF,                1'b1, 1'b1, 32'h437F_0000},
        '{TYPE_U8,   1'b0, 64'hFFFF_FFFF_FFFF_FF00, 1'b0, 1'b1, 32'h0000_0000},
        '{TYPE_BOOL, 1'b0, 64'h0,                 1'b0, 1'b1, 32'h0000_0000},
        '{TYPE_BOOL, 1'b0, 64'h80,                1'b1, 1'b1, F32_ONE},
        '{TYPE_I8,   1'b0, 64'h80,                1'b0, 1'b1, 32'hC300_0000},
        '{TYPE_I8,   1'b0, 64'h7F,                1'b0, 1'b0, 32'h0},
        '{TYPE_I16,  1'b1, 64'h0080,              1'b0, 1'b0, 32'h0},
        '{TYPE_U16,  1'b1, 64'hFFFF,              1'b1, 1'b0, 32'h0},
        '{TYPE_I32,  1'b0, 64'h8000_0000,         1'b0, 1'b1, 32'hCF00_0000},
        '{TYPE_U32,  1'b0, 64'hFFFF_FFFF,         1'b0, 1'b1, 32'h4F80_0000},
        '{TYPE_I64,  1'b0, 64'h8000_0000_0000_0000, 1'b0, 1'b1, 32'hDF00_0000},
        '{TYPE_U64,  1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 32'h5F80_0000},
        '{TYPE_U64,  1'b1, 64'h0000_0003_0000_0100, 1'b0, 1'b0, 32'h0},
        '{TYPE_F16,  1'b0, 64'h0001,              1'b0, 1'b0, 32'h0},
        '{TYPE_F16,  1'b0, 64'h7C00,              1'b0, 1'b1, F32_INF},
        '{TYPE_F16,  1'b0, 64'hFE01,              1'b0, 1'b0, 32'h0},
        '{TYPE_F16,  1'b1, 64'h003C,              1'b0, 1'b1, F32_ONE},
        '{TYPE_F32,  1'b0, 64'h7FC0_0001,         1'b0, 1'b1, 32'h7FC0_0001},
        '{TYPE_F64,  1'b0, 64'h7FF0_0000_0000_0000, 1'b0, 1'b1, F32_INF},
        '{TYPE_F64,  1'b0, 64'hFFF0_0000_2000_0001, 1'b0, 1'b0, 32'h0},
        '{TYPE_F64,  1'b0, 64'h47F0_0000_0000_0000, 1'b0, 1'b1, F32_INF},
        '{TYPE_F64,  1'b0, 64'h8000_0000_0000_0001, 1'b0, 1'b1, 32'h8000_0000},
        '{TYPE_F64,  1'b1, 64'h0000_0000_0000_9036, 1'b0, 1'b0, 32'h0},
        '{4'd15,     1'b1, 64'h1234_5678_9ABC_DEF0, 1'b1, 1'b1, 32'h0000_0000}
    };

    // Stimulus: reset, directed rows, then random phases over all type codes, each with a random byte order.
    initial
    begin
        logic [3:0] t;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_ELEMENT_TYPE;
        cfg_wdata = 4'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 64'd0;
        s_tlast   = 1'b0;
        cur_type  = TYPE_U8;
        cur_be    = 1'b0;
        idle_off  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].etype != cur_type || directed_rows[i].be != cur_be)
            begin
                s_tvalid <= 1'b0;
                write_settings(directed_rows[i].etype, directed_rows[i].be);
            end
            send_word(directed_rows[i].raw, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].want_bits);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            s_tvalid <= 1'b0;
            t = 4'(phase);
            write_settings(t, 1'($urandom_range(1)));
            idle_off = (phase % 4 == 1);
            for (int n = 0; n < PHASE_WORDS; n++)
                send_word(random_element(t), 1'($urandom_range(1)), 1'b0, 32'd0);
        end
        s_tvalid <= 1'b0;

        while (pending_floats.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (pending_floats.size() != 0)
        begin
            $error("%0d expected words never arrived", pending_floats.size());
            error_count++;
        end
        $display("Converted %0d words over all 16 type codes, both byte orders,", words_sent);
        $display("with %0d results checked under random input and output stalls.", words_checked);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Output side: random ready, one long hold-off, compare each word taken.
    initial
    begin
        m_tready    = 1'b0;
        error_count = 0;
        words_checked = 0;
        hold_done   = 1'b0;
        stall_left  = 0;
        forever
        begin
            float_word_t exp_word;
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_floats.size() == 0)
                begin
                    $error("unexpected word: float_bits %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    exp_word = pending_floats.pop_front();
                    words_checked++;
                    if (m_tdata !== exp_word.float_bits)
                    begin
                        $error("float_bits: expected %h, got %h", exp_word.float_bits, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== exp_word.last_out)
                    begin
                        $error("last_out: expected %b, got %b", exp_word.last_out, m_tlast);
                        error_count++;
                    end
                end
            end
            if (!hold_done && words_checked >= 300)
            begin
                hold_done  = 1'b1;
                stall_left = 200;
            end
            else if (stall_left == 0 && !idle_off)
                stall_left = idle_cycles();
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog.
    initial
    begin
        cycle_count = 0;
        words_sent  = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

endmodule
`default_nettype wire

// File: typed_element_to_float32_top.f
hdl/te2f_pkg.sv
hdl/te2f_front.sv
hdl/te2f_norm.sv
hdl/te2f_round.sv
hdl/typed_element_to_float32_top.sv
tb/sv/tb_typed_element_to_float32_top.sv
